[hdl/color_blob_zone_classifier_assert.svh]
// ----------------------------------------------------------------------------
// color blob zone classifier assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef COLOR_BLOB_ZONE_CLASSIFIER_ASSERT_SVH
`define COLOR_BLOB_ZONE_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define CBZC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbzc assertion failed");

// next-cycle implication, disabled while reset is held
`define CBZC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbzc assertion failed");

`endif

[hdl/cbzc_pkg.sv]
// ----------------------------------------------------------------------------
// cbzc_pkg
// types and constants shared by the colour blob zone classifier
// ----------------------------------------------------------------------------
package cbzc_pkg;

  localparam int MAX_IMAGE_WIDTH = 2048;
  localparam int COL_W           = 11;
  localparam int LEVEL_W         = 8;
  localparam int RADIUS_W        = 4;
  localparam int SPAN_W          = 12;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 11;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam col_t LEFTMOST_RESET = col_t'(MAX_IMAGE_WIDTH - 1);

  typedef enum logic [1:0] {
    CLS_UNKNOWN  = 2'd0,
    CLS_STRAIGHT = 2'd1,
    CLS_RIGHT    = 2'd2,
    CLS_LEFT     = 2'd3
  } pos_class_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_THR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_THR       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LEFT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_RIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_RADIUS = 3'd4;

  typedef struct packed {
    level_t              green_thr;
    level_t              red_thr;
    col_t                band_left;
    col_t                band_right;
    logic [RADIUS_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    col_t   column;
    level_t green;
    level_t red;
    logic   last;
  } pixel_t;

endpackage

[hdl/cbzc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cbzc_cfg_regs
// configuration register file, index decode and write masking
// ----------------------------------------------------------------------------
module cbzc_cfg_regs
  import cbzc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GREEN_THR:     cfg_nxt.green_thr  = cfg_wdata[LEVEL_W-1:0];
        CFG_RED_THR:       cfg_nxt.red_thr    = cfg_wdata[LEVEL_W-1:0];
        CFG_BAND_LEFT:     cfg_nxt.band_left  = cfg_wdata[COL_W-1:0];
        CFG_BAND_RIGHT:    cfg_nxt.band_right = cfg_wdata[COL_W-1:0];
        CFG_MARKER_RADIUS: cfg_nxt.radius     = cfg_wdata[RADIUS_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.green_thr  <= level_t'(50);
      cfg_r.red_thr    <= level_t'(50);
      cfg_r.band_left  <= col_t'(438);
      cfg_r.band_right <= col_t'(842);
      cfg_r.radius     <= RADIUS_W'(3);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/cbzc_pix_reg.sv]
// ----------------------------------------------------------------------------
// cbzc_pix_reg
// input register stage for the pixel stream
// ----------------------------------------------------------------------------
module cbzc_pix_reg
  import cbzc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  output logic        pix_valid,
  output pixel_t      pix,
  input  logic        pix_take
);

  logic   valid_r;
  pixel_t pix_r;

  // stage refills in the same cycle it drains
  assign in_tready = !valid_r || pix_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pix_r.column <= in_tdata[10:0];
      pix_r.green  <= in_tdata[18:11];
      pix_r.red    <= in_tdata[26:19];
      pix_r.last   <= in_tlast;
    end
  end

  assign pix_valid = valid_r;
  assign pix       = pix_r;

endmodule

[hdl/cbzc_zone_acc.sv]
// ----------------------------------------------------------------------------
// cbzc_zone_acc
// per-frame zone flags, lit column extremes and the result register
// ----------------------------------------------------------------------------
module cbzc_zone_acc
  import cbzc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        pix_valid,
  input  pixel_t      pix,
  output logic        pix_take,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  logic seen_left_r, seen_mid_r, seen_right_r;
  col_t leftmost_r, rightmost_r;
  logic out_valid_r;
  pos_class_t cls_r;
  logic signed [SPAN_W-1:0] span_r;

  logic lit, in_mid, in_left, in_right;
  logic seen_left_nxt, seen_mid_nxt, seen_right_nxt;
  col_t leftmost_nxt, rightmost_nxt;
  pos_class_t cls_nxt;
  logic signed [SPAN_W-1:0] span_nxt;
  logic slot_free;

  // a frame-end pixel waits only for the result slot; others never wait
  assign slot_free = !out_valid_r || out_tready;
  assign pix_take  = pix_valid && (!pix.last || slot_free);

  always_comb begin
    lit      = (pix.green > cfg.green_thr) && (pix.red < cfg.red_thr);
    in_mid   = (cfg.band_left < pix.column) && (pix.column < cfg.band_right);
    in_left  = !in_mid && (pix.column <= cfg.band_left);
    in_right = !in_mid && !in_left;

    seen_left_nxt  = seen_left_r  | (lit & in_left);
    seen_mid_nxt   = seen_mid_r   | (lit & in_mid);
    seen_right_nxt = seen_right_r | (lit & in_right);
    leftmost_nxt   = (lit && pix.column < leftmost_r)  ? pix.column : leftmost_r;
    rightmost_nxt  = (lit && pix.column > rightmost_r) ? pix.column : rightmost_r;

    cls_nxt  = CLS_UNKNOWN;
    span_nxt = '0;
    if (seen_mid_nxt && !seen_left_nxt && !seen_right_nxt) begin
      cls_nxt  = CLS_STRAIGHT;
      span_nxt = $signed({1'b0, rightmost_nxt} - {1'b0, leftmost_nxt}
                 - {{(SPAN_W-RADIUS_W-1){1'b0}}, cfg.radius, 1'b0});
    end else if (seen_right_nxt && !seen_left_nxt && !seen_mid_nxt) begin
      cls_nxt = CLS_RIGHT;
    end else if (seen_left_nxt && !seen_right_nxt && !seen_mid_nxt) begin
      cls_nxt = CLS_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_left_r  <= 1'b0;
      seen_mid_r   <= 1'b0;
      seen_right_r <= 1'b0;
      leftmost_r   <= LEFTMOST_RESET;
      rightmost_r  <= '0;
    end else if (pix_take) begin
      if (pix.last) begin
        // frame closed, start afresh
        seen_left_r  <= 1'b0;
        seen_mid_r   <= 1'b0;
        seen_right_r <= 1'b0;
        leftmost_r   <= LEFTMOST_RESET;
        rightmost_r  <= '0;
      end else begin
        seen_left_r  <= seen_left_nxt;
        seen_mid_r   <= seen_mid_nxt;
        seen_right_r <= seen_right_nxt;
        leftmost_r   <= leftmost_nxt;
        rightmost_r  <= rightmost_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pix_take && pix.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take && pix.last) begin
      cls_r  <= cls_nxt;
      span_r <= span_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, span_r, cls_r};

endmodule

[hdl/color_blob_zone_classifier.sv]
// ----------------------------------------------------------------------------
// color_blob_zone_classifier
// sorts lit pixels of a frame into zones and reports the marker position
// ----------------------------------------------------------------------------
//  channel  | ports                    | carries
//  ---------+--------------------------+--------------------------------------
//  in_      | tvalid tready tdata tlast| one pixel per transaction, tlast ends frame
//  out_     | tvalid tready tdata      | one class and span per frame
//  cfg_     | we index wdata           | register write, no read-back
//
//  one pixel per clock unless stalled; input register, one compare/min-max/subtract
//  stage into the result register, so a frame result appears in the cycle after
//  its last pixel is taken. reset is synchronous, active low, and restores the
//  register defaults and clears the frame state. a stalled result holds back
//  only the next frame-end pixel; once that pixel sits in the input register
//  the input stalls as well, ordinary pixels ahead of it keep flowing.
// ----------------------------------------------------------------------------
module color_blob_zone_classifier
  import cbzc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // column[10:0] green_level[18:11] red_level[26:19]
  input  logic                  in_tlast,   // frame_end
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // position_class[1:0] span_width[13:2]
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg;
  logic   pix_valid;
  pixel_t pix;
  logic   pix_take;

  cbzc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cbzc_pix_reg u_pix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_take  (pix_take)
  );

  cbzc_zone_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .pix_valid  (pix_valid),
    .pix        (pix),
    .pix_take   (pix_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[hdl/cbzc_checker.sv]
// ----------------------------------------------------------------------------
// cbzc_checker
// port-level checks on the classifier result stream
// ----------------------------------------------------------------------------
`include "color_blob_zone_classifier_assert.svh"

module cbzc_checker
  import cbzc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a held result keeps its value
  `CBZC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // only a straight class carries a span
  `CBZC_ASSERT_IMP(a_span_zero, clk, rst_n, out_tvalid && out_tdata[1:0] != CLS_STRAIGHT, out_tdata[13:2] == 12'd0)

  // straight means at least one lit column, so the span cannot fall below minus twice the radius
  `CBZC_ASSERT_IMP(a_span_floor, clk, rst_n, out_tvalid && out_tdata[1:0] == CLS_STRAIGHT, $signed(out_tdata[13:2]) >= -12'sd30)

  // padding bits stay clear
  `CBZC_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[15:14] == 2'b00)

endmodule

bind color_blob_zone_classifier cbzc_checker u_cbzc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/color_blob_zone_classifier_tb.sv]
// ----------------------------------------------------------------------------
// color_blob_zone_classifier_tb
// drives pixel frames through the zone classifier and checks each frame
// verdict against a cycle-free prediction of the zone flags and lit span;
// covers register extremes, crossed bounds, random frames and back-pressure
// ----------------------------------------------------------------------------
module color_blob_zone_classifier_tb;
  import cbzc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    pos_class_t  cls;
    logic [11:0] span;
  } zone_verdict_t;

  typedef enum logic [1:0] {
    Z_LEFT  = 2'd0,
    Z_MID   = 2'd1,
    Z_RIGHT = 2'd2,
    Z_NOISE = 2'd3
  } zone_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata   = '0;  // column[10:0] green_level[18:11] red_level[26:19]
  logic                  in_tlast   = 1'b0; // frame_end
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;        // position_class[1:0] span_width[13:2]
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // predictor state: register copy and per-frame zone tracking
  cfg_t zone_setup = '{green_thr: 8'd50, red_thr: 8'd50, band_left: 11'd438,
                       band_right: 11'd842, radius: 4'd3};
  logic hit_left    = 1'b0;
  logic hit_mid     = 1'b0;
  logic hit_right   = 1'b0;
  col_t lit_min_col = LEFTMOST_RESET;
  col_t lit_max_col = '0;

  zone_verdict_t verdicts_due[$];
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  color_blob_zone_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void absorb_pixel(pixel_t px);
    zone_verdict_t v;
    if (px.green > zone_setup.green_thr && px.red < zone_setup.red_thr) begin
      if (zone_setup.band_left < px.column && px.column < zone_setup.band_right) begin
        hit_mid = 1'b1;
      end else if (px.column <= zone_setup.band_left) begin
        hit_left = 1'b1;
      end else begin
        hit_right = 1'b1;
      end
      if (px.column < lit_min_col) lit_min_col = px.column;
      if (px.column > lit_max_col) lit_max_col = px.column;
    end
    if (!px.last) return;
    v.cls  = CLS_UNKNOWN;
    v.span = '0;
    if (hit_mid && !hit_left && !hit_right) begin
      v.cls  = CLS_STRAIGHT;
      v.span = 12'(lit_max_col) - 12'(lit_min_col) - 12'({zone_setup.radius, 1'b0});
    end else if (hit_right && !hit_left && !hit_mid) begin
      v.cls = CLS_RIGHT;
    end else if (hit_left && !hit_right && !hit_mid) begin
      v.cls = CLS_LEFT;
    end
    verdicts_due.insert(verdicts_due.size(), v);
    hit_left    = 1'b0;
    hit_mid     = 1'b0;
    hit_right   = 1'b0;
    lit_min_col = LEFTMOST_RESET;
    lit_max_col = '0;
  endfunction

  function automatic pixel_t make_pixel(int col, int g, int r, bit eof);
    pixel_t p;
    p.column = col_t'(col);
    p.green  = level_t'(g);
    p.red    = level_t'(r);
    p.last   = eof;
    return p;
  endfunction

  // random pixel aimed at one zone, lit or not under the current thresholds
  function automatic pixel_t gen_pixel(zone_t z, bit lit, bit eof);
    pixel_t p;
    int lo_b, hi_b, bl, br, g_thr, r_thr;
    bl     = int'(zone_setup.band_left);
    br     = int'(zone_setup.band_right);
    g_thr  = int'(zone_setup.green_thr);
    r_thr  = int'(zone_setup.red_thr);
    p.last   = eof;
    p.column = col_t'($urandom);
    p.green  = level_t'($urandom);
    p.red    = level_t'($urandom);
    if (z == Z_NOISE) return p;
    case (z)
      Z_LEFT: begin
        lo_b = 0;
        hi_b = bl;
      end
      Z_MID: begin
        lo_b = bl + 1;
        hi_b = br - 1;
      end
      default: begin
        lo_b = (br > bl) ? br : bl + 1;
        hi_b = MAX_IMAGE_WIDTH - 1;
      end
    endcase
    if (lo_b <= hi_b) p.column = col_t'($urandom_range(hi_b, lo_b));
    if (lit) begin
      if (g_thr < 255) p.green = level_t'($urandom_range(255, g_thr + 1));
      if (r_thr > 0) p.red = level_t'($urandom_range(r_thr - 1, 0));
    end else if ($urandom_range(1) != 0) begin
      p.green = level_t'($urandom_range(g_thr, 0));
    end else begin
      p.red = level_t'($urandom_range(255, r_thr));
    end
    return p;
  endfunction

  task automatic push_pixel(input pixel_t px);
    int gap;
    gap = 0;
    while (gap < 64 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, px.red, px.green, px.column};
    in_tlast  <= px.last;
    do @(posedge clk); while (!in_tready);
    absorb_pixel(px);
  endtask

  // lets the pipeline drain: every verdict in plus the block's own latency
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GREEN_THR:     zone_setup.green_thr  = value[LEVEL_W-1:0];
      CFG_RED_THR:       zone_setup.red_thr    = value[LEVEL_W-1:0];
      CFG_BAND_LEFT:     zone_setup.band_left  = value[COL_W-1:0];
      CFG_BAND_RIGHT:    zone_setup.band_right = value[COL_W-1:0];
      CFG_MARKER_RADIUS: zone_setup.radius     = value[RADIUS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_zone_setup(input int g, input int r, input int bl, input int br,
                                 input int rad);
    wait_idle();
    write_reg(CFG_GREEN_THR, CFG_DATA_W'(g));
    write_reg(CFG_RED_THR, CFG_DATA_W'(r));
    write_reg(CFG_BAND_LEFT, CFG_DATA_W'(bl));
    write_reg(CFG_BAND_RIGHT, CFG_DATA_W'(br));
    write_reg(CFG_MARKER_RADIUS, CFG_DATA_W'(rad));
  endtask

  task automatic send_random_frame(inout int sent);
    int len, plan;
    zone_t z;
    len  = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    plan = $urandom_range(9);
    for (int i = 0; i < len; i++) begin
      case (plan)
        0, 1, 2: z = Z_MID;
        3, 4:    z = Z_LEFT;
        5, 6:    z = Z_RIGHT;
        7, 8:    z = zone_t'($urandom_range(2));
        default: z = Z_NOISE;
      endcase
      push_pixel(gen_pixel(z, $urandom_range(2) != 0, i == len - 1));
      sent++;
    end
  endtask

  task automatic test_reset_defaults();
    push_pixel(make_pixel(500, 50, 0, 1));     // green at threshold, not lit
    push_pixel(make_pixel(500, 51, 50, 1));    // red at threshold, not lit
    push_pixel(make_pixel(439, 51, 49, 0));    // straight, both inner edges
    push_pixel(make_pixel(841, 255, 0, 1));
    push_pixel(make_pixel(438, 255, 0, 0));    // left only
    push_pixel(make_pixel(0, 200, 10, 1));
    push_pixel(make_pixel(842, 255, 0, 0));    // right only
    push_pixel(make_pixel(2047, 255, 0, 1));
    push_pixel(make_pixel(500, 255, 0, 0));    // two zones lit
    push_pixel(make_pixel(900, 255, 0, 1));
  endtask

  task automatic test_register_extremes();
    wait_idle();
    // upper data bits must be dropped, unused indexes must change nothing
    write_reg(CFG_GREEN_THR, 11'h714);
    for (int i = CFG_MARKER_RADIUS + 1; i < 2 ** CFG_IDX_W; i++) begin
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    end
    push_pixel(make_pixel(500, 21, 0, 1));     // single middle pixel, negative span

    load_zone_setup(0, 255, 1000, 500, 15);    // crossed bounds
    push_pixel(make_pixel(1000, 1, 0, 1));
    push_pixel(make_pixel(1001, 255, 0, 0));
    push_pixel(make_pixel(2047, 1, 254, 1));
    push_pixel(make_pixel(600, 0, 0, 1));
    push_pixel(make_pixel(600, 255, 255, 1));

    load_zone_setup(50, 50, 0, 2047, 15);      // widest middle zone
    push_pixel(make_pixel(1, 60, 0, 1));
    push_pixel(make_pixel(2046, 60, 0, 1));
    push_pixel(make_pixel(0, 60, 0, 1));
    push_pixel(make_pixel(2047, 60, 0, 1));

    load_zone_setup(255, 0, 438, 842, 0);      // nothing can light up
    push_pixel(make_pixel(600, 255, 0, 1));
  endtask

  task automatic test_random_traffic();
    int sent;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_zone_setup(50, 50, 438, 842, 3);
        1: load_zone_setup(0, 255, 0, 2047, 0);
        2: load_zone_setup(0, 255, 2047, 0, 15);
        7: load_zone_setup($urandom_range(200), $urandom_range(255, 30),
                           $urandom_range(2047, 1024), $urandom_range(1023),
                           $urandom_range(15));
        default: begin
          sent = $urandom_range(1800);
          load_zone_setup($urandom_range(200), $urandom_range(255, 30), sent,
                          sent + $urandom_range(247, 2), $urandom_range(15));
        end
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      sent = 0;
      while (sent < 200) send_random_frame(sent);
    end
  endtask

  task automatic test_output_holdoff();
    int sent;
    load_zone_setup(40, 80, 300, 1200, 5);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    sent = 0;
    while (sent < 40) send_random_frame(sent);
    // sender waits for every verdict before carrying on
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_verdicts
    zone_verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: expected no verdict, actual class %0d span %0d", $time,
                 out_tdata[1:0], $signed(out_tdata[13:2]));
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_tdata[1:0] !== want.cls) begin
          $display("%0t: position_class expected %0d actual %0d", $time,
                   want.cls, out_tdata[1:0]);
          mismatches++;
        end
        if (out_tdata[13:2] !== want.span) begin
          $display("%0t: span_width expected %0d actual %0d", $time,
                   $signed(want.span), $signed(out_tdata[13:2]));
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_output_holdoff();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("color_blob_zone_classifier_tb OK");
    end else begin
      $display("color_blob_zone_classifier_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("color_blob_zone_classifier_tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/cbzc_pkg.sv
hdl/cbzc_cfg_regs.sv
hdl/cbzc_pix_reg.sv
hdl/cbzc_zone_acc.sv
hdl/color_blob_zone_classifier.sv
hdl/cbzc_checker.sv
test/color_blob_zone_classifier_tb.sv
